// ===== rtl/weighted_geometric_median_assert.svh =====
// assertion macros used by the weighted geometric median checker
`ifndef WEIGHTED_GEOMETRIC_MEDIAN_ASSERT_SVH
`define WEIGHTED_GEOMETRIC_MEDIAN_ASSERT_SVH

// concurrent assertion on the rising clock, off while reset is low
`define WGM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// condition that must never hold
`define WGM_NEVER(label, clk, rstn, expr, msg) \
    `WGM_ASSERT(label, clk, rstn, !(expr), msg)

`endif

// ===== rtl/wgm_pkg.sv =====
// shared constants of the weighted geometric median block
`default_nettype none

package wgm_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_DIM    = 16;
    localparam int FRAC_BITS  = 16;

    localparam int PIDX_W  = $clog2(MAX_POINTS);
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int PADDR_W = PIDX_W + DIM_W;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);

    localparam int COORD_W    = 32;
    localparam int WEIGHT_W   = 32;
    localparam int POS_W      = 4;
    localparam int S_TDATA_W  = COORD_W + WEIGHT_W;
    localparam int M_TDATA_W  = ((COORD_W + POS_W + 7) / 8) * 8;

    localparam int DIMCFG_W   = 5;
    localparam int ITERCFG_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS     = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/wgm_ram.sv =====
// generic single-port synchronous ram with registered read
`default_nettype none

module wgm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/weighted_geometric_median.sv =====
// Weighted geometric median by Weiszfeld iterations over stored points. Coordinates
// arrive one per transfer at one per cycle while loading; a point shorter than 16
// coordinates has its unsent entries zeroed. On the final coordinate of the point
// marked last, a sequencer over the point, point-weight and iteration-weight memories
// runs iteration_count passes (one if zero; a single stored point is sent as it is).
// Each pass accumulates, forms the means (one shared 64-step restoring divider) and
// finds distances (32-step square root, then the same divider for the reciprocal).
// The median leaves as dim transfers, one per cycle while m_tready is high; no input
// is taken from the last point until the median's final coordinate is transferred.
`default_nettype none

module weighted_geometric_median (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // lowest bit up: coord_value[31:0], point_weight[63:32]
    input  wire logic [wgm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                              s_tlast,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // lowest bit up: median_coord[31:0], coord_position[35:32], zero fill
    output logic      [wgm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_wr_en,
    input  wire logic [wgm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wgm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int STATE_W = 5;
    localparam logic [STATE_W-1:0] S_LOAD      = 5'd0;
    localparam logic [STATE_W-1:0] S_FILL      = 5'd1;
    localparam logic [STATE_W-1:0] S_START     = 5'd2;
    localparam logic [STATE_W-1:0] S_SGL_RD    = 5'd3;
    localparam logic [STATE_W-1:0] S_SGL_WR    = 5'd4;
    localparam logic [STATE_W-1:0] S_ACC_CLR   = 5'd5;
    localparam logic [STATE_W-1:0] S_W_RD      = 5'd6;
    localparam logic [STATE_W-1:0] S_W_MUL     = 5'd7;
    localparam logic [STATE_W-1:0] S_W_SET     = 5'd8;
    localparam logic [STATE_W-1:0] S_P_RD      = 5'd9;
    localparam logic [STATE_W-1:0] S_P_MUL     = 5'd10;
    localparam logic [STATE_W-1:0] S_P_ACC     = 5'd11;
    localparam logic [STATE_W-1:0] S_MEAN      = 5'd12;
    localparam logic [STATE_W-1:0] S_MEAN_DIV  = 5'd13;
    localparam logic [STATE_W-1:0] S_D_RD      = 5'd14;
    localparam logic [STATE_W-1:0] S_D_ABS     = 5'd15;
    localparam logic [STATE_W-1:0] S_D_MUL     = 5'd16;
    localparam logic [STATE_W-1:0] S_D_ADD     = 5'd17;
    localparam logic [STATE_W-1:0] S_D_ROOT    = 5'd18;
    localparam logic [STATE_W-1:0] S_SQRT      = 5'd19;
    localparam logic [STATE_W-1:0] S_RECIP     = 5'd20;
    localparam logic [STATE_W-1:0] S_RECIP_DIV = 5'd21;
    localparam logic [STATE_W-1:0] S_OUT       = 5'd22;

    localparam int DIM_W   = wgm_pkg::DIM_W;
    localparam int PIDX_W  = wgm_pkg::PIDX_W;
    localparam int CNT_W   = wgm_pkg::CNT_W;
    localparam int F       = wgm_pkg::FRAC_BITS;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_W  = 7;

    localparam logic [DIM_W-1:0]  LAST_DIM   = DIM_W'(wgm_pkg::MAX_DIM - 1);
    localparam logic [31:0]       W_CAP      = 32'hFFFF_FFFF;
    localparam logic [31:0]       W_ONE      = 32'd1 << F;
    localparam logic [63:0]       RECIP_NUM  = 64'd1 << (2 * F);
    localparam logic [63:0]       ROUND_UP   = (64'd1 << F) - 64'd1;
    localparam logic [63:0]       SQRT_BIT0  = 64'h4000_0000_0000_0000;

    function automatic logic [31:0] sat_s32(input logic neg, input logic [63:0] mag);
        logic [63:0] negm;
        negm = ~mag + 64'd1;
        if (neg) begin
            sat_s32 = (mag > 64'h8000_0000) ? 32'h8000_0000 : negm[31:0];
        end else begin
            sat_s32 = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
    endfunction

    function automatic logic [63:0] sat_add_s64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] sum;
        sum = a + b;
        if ((a[63] == b[63]) && (sum[63] != a[63])) begin
            sat_add_s64 = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            sat_add_s64 = sum;
        end
    endfunction

    logic [STATE_W-1:0]         state_reg;
    logic [CNT_W-1:0]           pl_reg;
    logic [DIM_W-1:0]           cc_reg;
    logic [DIM_W-1:0]           fill_m_reg;
    logic                       last_reg;
    logic [PIDX_W-1:0]          p_reg;
    logic [DIM_W-1:0]           m_reg;
    logic [3:0]                 iter_reg;
    logic                       first_reg;
    logic [wgm_pkg::DIMCFG_W-1:0]  dim_count_reg;
    logic [wgm_pkg::ITERCFG_W-1:0] iter_count_reg;
    logic                       use_pw_reg;

    logic [63:0]                acc_reg [wgm_pkg::MAX_DIM];
    logic [31:0]                mean_reg [wgm_pkg::MAX_DIM];
    logic [63:0]                wt_reg;
    logic [31:0]                iw_eff_reg;
    logic [63:0]                wprod_reg;
    logic [31:0]                w0_reg;
    logic [63:0]                mprod_reg;
    logic [31:0]                am_reg;
    logic [63:0]                sq_reg;
    logic [63:0]                ss_reg;
    logic                       neg_reg;
    logic [64:0]                div_rem_reg;
    logic [63:0]                div_q_reg;
    logic [63:0]                den_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [63:0]                sq_v_reg;
    logic [63:0]                sq_r_reg;
    logic [63:0]                sq_bit_reg;

    logic [wgm_pkg::DIMCFG_W-1:0] dim_eff;
    logic [DIM_W-1:0]           dim_last;
    logic [3:0]                 iters_eff;
    logic                       room;
    logic                       s_fire;
    logic                       m_fire;
    logic                       coord_more;
    logic                       p_is_last;
    logic [31:0]                coord_in;
    logic [31:0]                pw_in;

    logic [wgm_pkg::PADDR_W-1:0] pt_addr;
    logic                       pt_we;
    logic [31:0]                pt_wdata;
    logic [31:0]                pt_rdata;
    logic [PIDX_W-1:0]          pw_addr;
    logic                       pw_we;
    logic [31:0]                pw_rdata;
    logic                       iw_we;
    logic [31:0]                iw_wdata;
    logic [31:0]                iw_rdata;

    logic [31:0]                iw_eff;
    logic [63:0]                wshift;
    logic [31:0]                w0_calc;
    logic [64:0]                wt_sum;
    logic signed [65:0]         mprod_full;
    logic [32:0]                df;
    logic [32:0]                df_neg;
    logic [63:0]                acc_sel;
    logic [63:0]                acc_neg;
    logic [63:0]                mag;
    logic [63:0]                q_zero;
    logic [64:0]                ss_sum;
    logic [64:0]                div_shift;
    logic                       div_ge;
    logic [64:0]                div_rem_step;
    logic                       div_done;
    logic [63:0]                sqrt_sum;
    logic                       sqrt_ge;
    logic [63:0]                recip_q;

    always_comb begin
        if (dim_count_reg == '0) begin
            dim_eff = wgm_pkg::DIMCFG_W'(1);
        end else if (dim_count_reg > wgm_pkg::DIMCFG_W'(wgm_pkg::MAX_DIM)) begin
            dim_eff = wgm_pkg::DIMCFG_W'(wgm_pkg::MAX_DIM);
        end else begin
            dim_eff = dim_count_reg;
        end
    end

    assign dim_last   = DIM_W'(dim_eff - wgm_pkg::DIMCFG_W'(1));
    assign iters_eff  = (iter_count_reg == '0) ? 4'd1 : iter_count_reg;
    assign room       = pl_reg < CNT_W'(wgm_pkg::MAX_POINTS);
    assign s_tready   = (state_reg == S_LOAD);
    assign s_fire     = s_tvalid && s_tready;
    assign m_tvalid   = (state_reg == S_OUT);
    assign m_fire     = m_tvalid && m_tready;
    assign coord_in   = s_tdata[wgm_pkg::COORD_W-1:0];
    assign pw_in      = s_tdata[wgm_pkg::S_TDATA_W-1:wgm_pkg::COORD_W];
    assign coord_more = (wgm_pkg::DIMCFG_W'(cc_reg) + wgm_pkg::DIMCFG_W'(1)) < dim_eff;
    assign p_is_last  = (CNT_W'(p_reg) == (pl_reg - CNT_W'(1)));

    assign m_tdata = {(wgm_pkg::M_TDATA_W - wgm_pkg::COORD_W - wgm_pkg::POS_W)'(0),
                      wgm_pkg::POS_W'(m_reg), mean_reg[m_reg]};
    assign m_tlast = (m_reg == dim_last);

    // memory ports
    always_comb begin
        case (state_reg)
            S_LOAD:  pt_addr = {pl_reg[PIDX_W-1:0], cc_reg};
            S_FILL:  pt_addr = {pl_reg[PIDX_W-1:0], fill_m_reg};
            default: pt_addr = {p_reg, m_reg};
        endcase
    end

    assign pt_we    = (s_fire && room) || (state_reg == S_FILL);
    assign pt_wdata = (state_reg == S_FILL) ? 32'd0 : coord_in;
    assign pw_addr  = (state_reg == S_LOAD) ? pl_reg[PIDX_W-1:0] : p_reg;
    assign pw_we    = s_fire && room && (cc_reg == '0);

    // arithmetic
    assign iw_eff     = first_reg ? W_ONE : iw_rdata;
    assign wshift     = wprod_reg >> F;
    assign w0_calc    = use_pw_reg ? ((|wshift[63:32]) ? W_CAP : wshift[31:0]) : iw_eff_reg;
    assign wt_sum     = {1'b0, wt_reg} + {33'd0, w0_calc};
    assign mprod_full = $signed(pt_rdata) * $signed({1'b0, w0_reg});
    assign df         = {pt_rdata[31], pt_rdata} - {mean_reg[m_reg][31], mean_reg[m_reg]};
    assign df_neg     = ~df + 33'd1;
    assign acc_sel    = acc_reg[m_reg];
    assign acc_neg    = ~acc_sel + 64'd1;
    assign mag        = acc_sel[63] ? acc_neg : acc_sel;
    assign q_zero     = acc_sel[63] ? ((mag + ROUND_UP) >> F) : (mag >> F);
    assign ss_sum     = {1'b0, ss_reg} + {1'b0, sq_reg};

    assign div_shift    = {div_rem_reg[63:0], div_q_reg[63]};
    assign div_ge       = div_shift >= {1'b0, den_reg};
    assign div_rem_step = div_ge ? (div_shift - {1'b0, den_reg}) : div_shift;
    assign div_done     = (step_reg == STEP_W'(DIV_STEPS));
    assign recip_q      = (|div_q_reg[63:32]) ? {32'd0, W_CAP} : div_q_reg;

    assign sqrt_sum = sq_r_reg + sq_bit_reg;
    assign sqrt_ge  = sq_v_reg >= sqrt_sum;

    always_comb begin
        iw_we    = 1'b0;
        iw_wdata = 32'd0;
        case (state_reg)
            S_D_ROOT: begin
                iw_we    = (ss_reg == '0);
                iw_wdata = 32'd0;
            end
            S_RECIP: begin
                iw_we    = (sq_r_reg == '0);
                iw_wdata = W_CAP;
            end
            S_RECIP_DIV: begin
                iw_we    = div_done;
                iw_wdata = recip_q[31:0];
            end
            default: begin
                iw_we    = 1'b0;
                iw_wdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            pl_reg         <= '0;
            cc_reg         <= '0;
            fill_m_reg     <= '0;
            last_reg       <= 1'b0;
            p_reg          <= '0;
            m_reg          <= '0;
            iter_reg       <= '0;
            first_reg      <= 1'b0;
            step_reg       <= '0;
            wt_reg         <= '0;
            dim_count_reg  <= wgm_pkg::DIMCFG_W'(1);
            iter_count_reg <= wgm_pkg::ITERCFG_W'(10);
            use_pw_reg     <= 1'b1;
            for (int i = 0; i < wgm_pkg::MAX_DIM; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    wgm_pkg::REG_DIM_COUNT:       dim_count_reg  <= cfg_wdata;
                    wgm_pkg::REG_ITERATION_COUNT: iter_count_reg <= cfg_wdata[3:0];
                    wgm_pkg::REG_USE_WEIGHTS:     use_pw_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_LOAD: begin
                    if (s_fire) begin
                        if (coord_more) begin
                            cc_reg <= cc_reg + DIM_W'(1);
                        end else begin
                            cc_reg <= '0;
                            if (room) begin
                                if (cc_reg != LAST_DIM) begin
                                    fill_m_reg <= cc_reg + DIM_W'(1);
                                    last_reg   <= s_tlast;
                                    state_reg  <= S_FILL;
                                end else begin
                                    pl_reg <= pl_reg + CNT_W'(1);
                                    if (s_tlast) begin
                                        state_reg <= S_START;
                                    end
                                end
                            end else if (s_tlast) begin
                                state_reg <= S_START;
                            end
                        end
                    end
                end
                S_FILL: begin
                    if (fill_m_reg == LAST_DIM) begin
                        pl_reg    <= pl_reg + CNT_W'(1);
                        state_reg <= last_reg ? S_START : S_LOAD;
                    end else begin
                        fill_m_reg <= fill_m_reg + DIM_W'(1);
                    end
                end
                S_START: begin
                    p_reg <= '0;
                    m_reg <= '0;
                    if (pl_reg == CNT_W'(1)) begin
                        state_reg <= S_SGL_RD;
                    end else begin
                        iter_reg  <= 4'd1;
                        first_reg <= 1'b1;
                        state_reg <= S_ACC_CLR;
                    end
                end
                S_SGL_RD: begin
                    state_reg <= S_SGL_WR;
                end
                S_SGL_WR: begin
                    mean_reg[m_reg] <= pt_rdata;
                    if (m_reg == dim_last) begin
                        m_reg     <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        m_reg     <= m_reg + DIM_W'(1);
                        state_reg <= S_SGL_RD;
                    end
                end
                S_ACC_CLR: begin
                    for (int i = 0; i < wgm_pkg::MAX_DIM; i++) begin
                        acc_reg[i] <= '0;
                    end
                    wt_reg    <= '0;
                    p_reg     <= '0;
                    state_reg <= S_W_RD;
                end
                S_W_RD: begin
                    state_reg <= S_W_MUL;
                end
                S_W_MUL: begin
                    iw_eff_reg <= iw_eff;
                    wprod_reg  <= iw_eff * pw_rdata;
                    state_reg  <= S_W_SET;
                end
                S_W_SET: begin
                    w0_reg    <= w0_calc;
                    wt_reg    <= wt_sum[64] ? {64{1'b1}} : wt_sum[63:0];
                    m_reg     <= '0;
                    state_reg <= S_P_RD;
                end
                S_P_RD: begin
                    state_reg <= S_P_MUL;
                end
                S_P_MUL: begin
                    mprod_reg <= mprod_full[63:0];
                    state_reg <= S_P_ACC;
                end
                S_P_ACC: begin
                    acc_reg[m_reg] <= sat_add_s64(acc_reg[m_reg], mprod_reg);
                    if (m_reg == dim_last) begin
                        m_reg <= '0;
                        if (p_is_last) begin
                            state_reg <= S_MEAN;
                        end else begin
                            p_reg     <= p_reg + PIDX_W'(1);
                            state_reg <= S_W_RD;
                        end
                    end else begin
                        m_reg     <= m_reg + DIM_W'(1);
                        state_reg <= S_P_RD;
                    end
                end
                S_MEAN: begin
                    if (wt_reg == '0) begin
                        mean_reg[m_reg] <= sat_s32(acc_sel[63], q_zero);
                        if (m_reg == dim_last) begin
                            m_reg     <= '0;
                            p_reg     <= '0;
                            ss_reg    <= '0;
                            state_reg <= S_D_RD;
                        end else begin
                            m_reg <= m_reg + DIM_W'(1);
                        end
                    end else begin
                        neg_reg     <= acc_sel[63];
                        div_rem_reg <= '0;
                        div_q_reg   <= mag;
                        den_reg     <= wt_reg;
                        step_reg    <= '0;
                        state_reg   <= S_MEAN_DIV;
                    end
                end
                S_MEAN_DIV: begin
                    if (div_done) begin
                        mean_reg[m_reg] <= sat_s32(neg_reg, div_q_reg);
                        if (m_reg == dim_last) begin
                            m_reg     <= '0;
                            p_reg     <= '0;
                            ss_reg    <= '0;
                            state_reg <= S_D_RD;
                        end else begin
                            m_reg     <= m_reg + DIM_W'(1);
                            state_reg <= S_MEAN;
                        end
                    end else begin
                        div_rem_reg <= div_rem_step;
                        div_q_reg   <= {div_q_reg[62:0], div_ge};
                        step_reg    <= step_reg + STEP_W'(1);
                    end
                end
                S_D_RD: begin
                    state_reg <= S_D_ABS;
                end
                S_D_ABS: begin
                    am_reg    <= df[32] ? df_neg[31:0] : df[31:0];
                    state_reg <= S_D_MUL;
                end
                S_D_MUL: begin
                    sq_reg    <= {32'd0, am_reg} * {32'd0, am_reg};
                    state_reg <= S_D_ADD;
                end
                S_D_ADD: begin
                    ss_reg <= ss_sum[64] ? {64{1'b1}} : ss_sum[63:0];
                    if (m_reg == dim_last) begin
                        state_reg <= S_D_ROOT;
                    end else begin
                        m_reg     <= m_reg + DIM_W'(1);
                        state_reg <= S_D_RD;
                    end
                end
                S_D_ROOT: begin
                    if (ss_reg == '0) begin
                        state_reg <= S_RECIP_DIV;
                        step_reg  <= STEP_W'(DIV_STEPS + 1);
                    end else begin
                        sq_v_reg   <= ss_reg;
                        sq_r_reg   <= '0;
                        sq_bit_reg <= SQRT_BIT0;
                        step_reg   <= '0;
                        state_reg  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (step_reg == STEP_W'(SQRT_STEPS)) begin
                        state_reg <= S_RECIP;
                    end else begin
                        if (sqrt_ge) begin
                            sq_v_reg <= sq_v_reg - sqrt_sum;
                            sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                        end else begin
                            sq_r_reg <= sq_r_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                        step_reg   <= step_reg + STEP_W'(1);
                    end
                end
                S_RECIP: begin
                    if (sq_r_reg == '0) begin
                        state_reg <= S_RECIP_DIV;
                        step_reg  <= STEP_W'(DIV_STEPS + 1);
                    end else begin
                        div_rem_reg <= '0;
                        div_q_reg   <= RECIP_NUM;
                        den_reg     <= sq_r_reg;
                        step_reg    <= '0;
                        state_reg   <= S_RECIP_DIV;
                    end
                end
                S_RECIP_DIV: begin
                    // past the last step means the weight was already written
                    if (div_done || (step_reg == STEP_W'(DIV_STEPS + 1))) begin
                        m_reg <= '0;
                        if (p_is_last) begin
                            if (iter_reg == iters_eff) begin
                                state_reg <= S_OUT;
                            end else begin
                                iter_reg  <= iter_reg + 4'd1;
                                first_reg <= 1'b0;
                                state_reg <= S_ACC_CLR;
                            end
                        end else begin
                            p_reg     <= p_reg + PIDX_W'(1);
                            ss_reg    <= '0;
                            state_reg <= S_D_RD;
                        end
                    end else begin
                        div_rem_reg <= div_rem_step;
                        div_q_reg   <= {div_q_reg[62:0], div_ge};
                        step_reg    <= step_reg + STEP_W'(1);
                    end
                end
                S_OUT: begin
                    if (m_fire) begin
                        if (m_tlast) begin
                            m_reg     <= '0;
                            pl_reg    <= '0;
                            state_reg <= S_LOAD;
                        end else begin
                            m_reg <= m_reg + DIM_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    wgm_ram #(
        .WIDTH (32),
        .DEPTH (wgm_pkg::MAX_POINTS * wgm_pkg::MAX_DIM)
    ) u_point_ram (
        .clk   (aclk),
        .we    (pt_we),
        .addr  (pt_addr),
        .wdata (pt_wdata),
        .rdata (pt_rdata)
    );

    wgm_ram #(
        .WIDTH (32),
        .DEPTH (wgm_pkg::MAX_POINTS)
    ) u_pw_ram (
        .clk   (aclk),
        .we    (pw_we),
        .addr  (pw_addr),
        .wdata (pw_in),
        .rdata (pw_rdata)
    );

    wgm_ram #(
        .WIDTH (32),
        .DEPTH (wgm_pkg::MAX_POINTS)
    ) u_iw_ram (
        .clk   (aclk),
        .we    (iw_we),
        .addr  (p_reg),
        .wdata (iw_wdata),
        .rdata (iw_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/wgm_checker.sv =====
// port-level assertions for the weighted geometric median block, with its bind
`default_nettype none
`include "weighted_geometric_median_assert.svh"

module wgm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [wgm_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);

    `WGM_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `WGM_NEVER(a_no_overlap, aclk, aresetn, s_tready && m_tvalid, "input taken while median is out")
    `WGM_ASSERT(a_first_pos, aclk, aresetn, $rose(m_tvalid) |-> m_tdata[wgm_pkg::COORD_W +: wgm_pkg::POS_W] == 4'd0, "median does not start at coordinate zero")
    `WGM_ASSERT(a_pos_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tdata[wgm_pkg::COORD_W +: wgm_pkg::POS_W] == $past(m_tdata[wgm_pkg::COORD_W +: wgm_pkg::POS_W]) + 4'd1), "coordinate position skipped")

endmodule

bind weighted_geometric_median wgm_checker u_wgm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
